// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assertion macros
// short wrappers for clocked concurrent checks with async active-low reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every edge out of reset
`define CHK_ALWAYS(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define CHK_IMPLY(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ssa_pkg.sv =====
// ----------------------------------------------------------------------------
// ssa_pkg
// shared widths, codes and types of the stick scaling and arming block
// ----------------------------------------------------------------------------
package ssa_pkg;

	localparam int STICK_W = 12;
	localparam int SCALE_W = 8;
	localparam int CMD_W   = 15;
	localparam int ARM_W   = 2;
	localparam int IDX_W   = 2;
	localparam int DATA_W  = 12;
	localparam int LANES   = 3;

	// magnitude of (x - center) * 4
	localparam int MAG_W   = 14;

	localparam logic [STICK_W-1:0] CENTER_US   = 12'd1500;
	localparam logic [STICK_W-1:0] LOW_THR_RST = 12'd1100;
	localparam logic [STICK_W-1:0] HI_THR_RST  = 12'd1900;
	localparam logic [SCALE_W-1:0] SCALE_RST   = 8'd4;

	// register indexes
	localparam logic [IDX_W-1:0] REG_LOW_THR  = 2'd0;
	localparam logic [IDX_W-1:0] REG_HIGH_THR = 2'd1;
	localparam logic [IDX_W-1:0] REG_RP_SCALE = 2'd2;
	localparam logic [IDX_W-1:0] REG_YAW_SCALE = 2'd3;

	// reported arming codes
	localparam logic [ARM_W-1:0] ARM_OFF  = 2'd0;
	localparam logic [ARM_W-1:0] ARM_PEND = 2'd1;
	localparam logic [ARM_W-1:0] ARM_ON   = 2'd2;

	typedef struct packed {
		logic [ARM_W-1:0] status;
		logic             clear_integrals;
		logic             clear_feedback;
		logic             rezero_request;
	} arm_flags_t;

	typedef struct packed {
		logic                    done;
		logic signed [CMD_W-1:0] value;
	} lane_res_t;

endpackage

// ===== hw/rtl/ssa_ifs.sv =====
// ----------------------------------------------------------------------------
// ssa channel interfaces
// frame input, command output and register write channels
// ----------------------------------------------------------------------------
interface ssa_frame_if;
	import ssa_pkg::*;
	logic               valid;
	logic               ready;
	logic [STICK_W-1:0] roll_in;
	logic [STICK_W-1:0] pitch_in;
	logic [STICK_W-1:0] yaw_in;
	logic [STICK_W-1:0] throttle_in;
	modport source (output valid, roll_in, pitch_in, yaw_in, throttle_in, input ready);
	modport sink   (input valid, roll_in, pitch_in, yaw_in, throttle_in, output ready);
endinterface

interface ssa_cmd_if;
	import ssa_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [CMD_W-1:0] roll_out;
	logic signed [CMD_W-1:0] pitch_out;
	logic signed [CMD_W-1:0] yaw_out;
	logic [STICK_W-1:0]      throttle_out;
	logic [ARM_W-1:0]        arm_status;
	logic                    clear_integrals;
	logic                    clear_feedback;
	logic                    rezero_request;
	modport source (output valid, roll_out, pitch_out, yaw_out, throttle_out, arm_status,
		clear_integrals, clear_feedback, rezero_request, input ready);
	modport sink   (input valid, roll_out, pitch_out, yaw_out, throttle_out, arm_status,
		clear_integrals, clear_feedback, rezero_request, output ready);
endinterface

interface ssa_cfg_if;
	import ssa_pkg::*;
	logic              valid;
	logic              ready;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/ssa_div_lane.sv =====
// ----------------------------------------------------------------------------
// ssa_div_lane
// one rescale lane: (x - 1500) * 4 / scale + 1500, restoring divider
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ssa_div_lane (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           ack,
	input  logic [ssa_pkg::STICK_W-1:0]    x,
	input  logic [ssa_pkg::SCALE_W-1:0]    scale,
	output ssa_pkg::lane_res_t             res
);
	import ssa_pkg::*;

	typedef enum logic [2:0] {
		L_IDLE = 3'b001,
		L_RUN  = 3'b010,
		L_DONE = 3'b100
	} lane_state_t;

	localparam int CNT_W = $clog2(MAG_W);

	lane_state_t              state_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [MAG_W-1:0]         acc_q;
	logic [SCALE_W-1:0]       rem_q;
	logic [SCALE_W-1:0]       div_q;
	logic                     neg_q;

	logic signed [STICK_W:0]  diff;
	logic [STICK_W-1:0]       abs_diff;
	logic [SCALE_W:0]         trial;
	logic                     ge;
	logic [SCALE_W:0]         trial_sub;
	logic [CMD_W-1:0]         q_ext;
	logic [CMD_W-1:0]         q_signed;

	// signed offset from center, magnitude times four
	assign diff     = $signed({1'b0, x}) - $signed({1'b0, CENTER_US});
	assign abs_diff = diff[STICK_W] ? STICK_W'(-diff) : diff[STICK_W-1:0];

	// one quotient bit per cycle
	assign trial     = {rem_q, acc_q[MAG_W-1]};
	assign ge        = trial >= {1'b0, div_q};
	assign trial_sub = trial - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				L_IDLE: begin
					if (start) begin
						state_q <= L_RUN;
						cnt_q   <= CNT_W'(MAG_W - 1);
					end
				end
				L_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= L_DONE;
					end
				end
				L_DONE: begin
					if (ack) begin
						state_q <= L_IDLE;
					end
				end
				default: begin
					state_q <= L_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == L_IDLE && start) begin
			acc_q <= {abs_diff, 2'b00};
			rem_q <= '0;
			div_q <= (scale == '0) ? SCALE_W'(1) : scale;
			neg_q <= diff[STICK_W];
		end else if (state_q == L_RUN) begin
			acc_q <= {acc_q[MAG_W-2:0], ge};
			rem_q <= ge ? trial_sub[SCALE_W-1:0] : trial[SCALE_W-1:0];
		end
	end

	assign q_ext    = {1'b0, acc_q};
	assign q_signed = neg_q ? CMD_W'(-q_ext) : q_ext;

	assign res.done  = (state_q == L_DONE);
	assign res.value = $signed(q_signed + CMD_W'(CENTER_US));

	`CHK_IMPLY(a_start_idle, clk, arst_n, start, state_q == L_IDLE, "lane started while busy")
	`CHK_IMPLY(a_rem_below, clk, arst_n, state_q == L_RUN, rem_q < div_q,
		"partial remainder not below divisor")
	`CHK_NEXT(a_run_ends, clk, arst_n, state_q == L_RUN && cnt_q == '0, state_q == L_DONE,
		"divider did not finish on last step")

endmodule

// ===== hw/rtl/ssa_arm.sv =====
// ----------------------------------------------------------------------------
// ssa_arm
// stick-gesture arming machine and pulse flags for one frame
// ----------------------------------------------------------------------------
module ssa_arm (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        update,
	input  logic [ssa_pkg::STICK_W-1:0] roll,
	input  logic [ssa_pkg::STICK_W-1:0] pitch,
	input  logic [ssa_pkg::STICK_W-1:0] yaw,
	input  logic [ssa_pkg::STICK_W-1:0] throttle,
	input  logic [ssa_pkg::STICK_W-1:0] low_thr,
	input  logic [ssa_pkg::STICK_W-1:0] high_thr,
	output ssa_pkg::arm_flags_t         flags
);
	import ssa_pkg::*;

	typedef enum logic [2:0] {
		A_OFF  = 3'b001,
		A_PEND = 3'b010,
		A_ON   = 3'b100
	} arm_state_t;

	arm_state_t state_q;
	arm_state_t state_d;
	logic       thr_low;
	logic       yaw_high;
	logic       yaw_low;
	logic       fb;

	assign thr_low  = throttle < low_thr;
	assign yaw_high = yaw > high_thr;
	assign yaw_low  = yaw < low_thr;

	// steps in model order: pending->armed, disarmed->pending, low yaw disarms
	always_comb begin
		state_d = state_q;
		fb      = 1'b0;
		if (thr_low) begin
			if (yaw_high && state_q == A_PEND) begin
				state_d = A_ON;
				fb      = 1'b1;
			end else if (yaw_high && state_q == A_OFF) begin
				state_d = A_PEND;
			end
			if (yaw_low) begin
				state_d = A_OFF;
			end
		end
	end

	always_comb begin
		case (state_d)
			A_OFF:   flags.status = ARM_OFF;
			A_PEND:  flags.status = ARM_PEND;
			A_ON:    flags.status = ARM_ON;
			default: flags.status = ARM_OFF;
		endcase
		flags.clear_integrals = thr_low;
		flags.clear_feedback  = fb;
		flags.rezero_request  = thr_low && yaw_low && (roll > high_thr) && (pitch < low_thr);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= A_OFF;
		end else if (update) begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hw/rtl/stick_scaling_and_arming.sv =====
// ----------------------------------------------------------------------------
// stick_scaling_and_arming
// rescales roll, pitch and yaw about center and runs the stick arming machine
// ----------------------------------------------------------------------------
// usage
// - frame: valid/ready channel, one item is one radio frame of four widths
// - cmd: valid/ready channel, one item per frame: three rescaled sticks,
//   throttle, arming status and three one-frame pulse flags
// - cfg: register writes (index, data), always ready; write only while idle
// - one frame in flight: frame.ready is high only while the lanes are free
// - each lane runs its 14-step restoring divider from frame accept; the merge
//   stage then registers the result and raises cmd.valid once the output is free
// - a new frame is accepted only after the last one is loaded into the output register
// - three divider lanes run in parallel, roll and pitch with roll_pitch_scale,
//   yaw with yaw_scale; the merge stage adds the arming flags and registers
// - a stalled cmd holds its item; finished lanes wait, frame.ready stays low
// - reset: arming state disarmed, registers at their defaults, channels empty
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stick_scaling_and_arming (
	input  logic       clk,
	input  logic       arst_n,
	ssa_frame_if.sink  frame,
	ssa_cmd_if.source  cmd,
	ssa_cfg_if.sink    cfg
);
	import ssa_pkg::*;

	// configuration registers
	logic [STICK_W-1:0] low_thr_q;
	logic [STICK_W-1:0] high_thr_q;
	logic [SCALE_W-1:0] rp_scale_q;
	logic [SCALE_W-1:0] yaw_scale_q;

	// frame held for the merge stage
	logic [STICK_W-1:0] roll_q;
	logic [STICK_W-1:0] pitch_q;
	logic [STICK_W-1:0] yaw_q;
	logic [STICK_W-1:0] thr_q;
	logic               busy_q;

	// output register
	logic                    out_valid_q;
	logic signed [CMD_W-1:0] roll_out_q;
	logic signed [CMD_W-1:0] pitch_out_q;
	logic signed [CMD_W-1:0] yaw_out_q;
	logic [STICK_W-1:0]      thr_out_q;
	arm_flags_t              flags_out_q;

	logic               accept;
	logic               all_done;
	logic               load;
	logic [STICK_W-1:0] lane_x     [LANES];
	logic [SCALE_W-1:0] lane_scale [LANES];
	lane_res_t          lane_r     [LANES];
	arm_flags_t         arm_flags;

	assign cfg.ready   = 1'b1;
	assign frame.ready = !busy_q;
	assign accept      = frame.valid && frame.ready;

	// register writes, all indexes in use
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q   <= LOW_THR_RST;
			high_thr_q  <= HI_THR_RST;
			rp_scale_q  <= SCALE_RST;
			yaw_scale_q <= SCALE_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_LOW_THR:   low_thr_q   <= cfg.data[STICK_W-1:0];
				REG_HIGH_THR:  high_thr_q  <= cfg.data[STICK_W-1:0];
				REG_RP_SCALE:  rp_scale_q  <= cfg.data[SCALE_W-1:0];
				REG_YAW_SCALE: yaw_scale_q <= cfg.data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	// lane 0 roll, lane 1 pitch, lane 2 yaw
	assign lane_x[0]     = frame.roll_in;
	assign lane_x[1]     = frame.pitch_in;
	assign lane_x[2]     = frame.yaw_in;
	assign lane_scale[0] = rp_scale_q;
	assign lane_scale[1] = rp_scale_q;
	assign lane_scale[2] = yaw_scale_q;

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		ssa_div_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (accept),
			.ack    (load),
			.x      (lane_x[i]),
			.scale  (lane_scale[i]),
			.res    (lane_r[i])
		);
	end

	// arming runs on the held frame and commits when the result is loaded
	ssa_arm u_arm (
		.clk      (clk),
		.arst_n   (arst_n),
		.update   (load),
		.roll     (roll_q),
		.pitch    (pitch_q),
		.yaw      (yaw_q),
		.throttle (thr_q),
		.low_thr  (low_thr_q),
		.high_thr (high_thr_q),
		.flags    (arm_flags)
	);

	// merge: all lanes done and the output register free or being emptied
	assign all_done = lane_r[0].done && lane_r[1].done && lane_r[2].done;
	assign load     = busy_q && all_done && (!out_valid_q || cmd.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (load) begin
				busy_q <= 1'b0;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (cmd.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			roll_q  <= frame.roll_in;
			pitch_q <= frame.pitch_in;
			yaw_q   <= frame.yaw_in;
			thr_q   <= frame.throttle_in;
		end
		if (load) begin
			roll_out_q  <= lane_r[0].value;
			pitch_out_q <= lane_r[1].value;
			yaw_out_q   <= lane_r[2].value;
			thr_out_q   <= thr_q;
			flags_out_q <= arm_flags;
		end
	end

	assign cmd.valid           = out_valid_q;
	assign cmd.roll_out        = roll_out_q;
	assign cmd.pitch_out       = pitch_out_q;
	assign cmd.yaw_out         = yaw_out_q;
	assign cmd.throttle_out    = thr_out_q;
	assign cmd.arm_status      = flags_out_q.status;
	assign cmd.clear_integrals = flags_out_q.clear_integrals;
	assign cmd.clear_feedback  = flags_out_q.clear_feedback;
	assign cmd.rezero_request  = flags_out_q.rezero_request;

	`CHK_NEXT(a_accept_busy, clk, arst_n, accept, busy_q, "frame accepted without going busy")
	`CHK_ALWAYS(a_lanes_lockstep, clk, arst_n,
		lane_r[0].done == lane_r[1].done && lane_r[1].done == lane_r[2].done,
		"divider lanes out of step")
	`CHK_IMPLY(a_status_code, clk, arst_n, cmd.valid,
		cmd.arm_status == ARM_OFF || cmd.arm_status == ARM_PEND || cmd.arm_status == ARM_ON,
		"unreachable arming code reported")

endmodule

// ===== sim/stick_scaling_and_arming_tb.sv =====
// ----------------------------------------------------------------------------
// stick_scaling_and_arming_tb
// self-checking bench for stick rescaling, throttle pass-through and the
// arming gestures: a directed table first, then randomized gesture-heavy
// frames under several register settings, with bursty input and a stalling
// command receiver; each command is compared with a typed row or a predictor
// ----------------------------------------------------------------------------
module stick_scaling_and_arming_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ssa_pkg::*;

	localparam int HALF_PERIOD      = 5;
	localparam int RESET_CYCLES     = 11;
	localparam int UNITY_GAIN       = 4;
	localparam int PHASES           = 8;
	localparam int FRAMES_PER_PHASE = 190;
	localparam int SETTLE_CYCLES    = 24;    // block latency plus margin
	localparam int WATCHDOG_LIMIT   = 1000;  // cycles with no handshake at all
	localparam int MAX_REPORTS      = 10;
	localparam int DIR_N            = 30;

	// one radio frame as driven on the frame channel
	typedef struct packed {
		logic [STICK_W-1:0] roll;
		logic [STICK_W-1:0] pitch;
		logic [STICK_W-1:0] yaw;
		logic [STICK_W-1:0] throttle;
	} sticks_t;

	// one command item as seen on the cmd channel
	typedef struct packed {
		logic signed [CMD_W-1:0] roll;
		logic signed [CMD_W-1:0] pitch;
		logic signed [CMD_W-1:0] yaw;
		logic [STICK_W-1:0]      throttle;
		arm_flags_t              flags;
	} command_t;

	typedef enum logic {ROW_FRAME, ROW_WRITE} row_kind_e;

	typedef struct packed {
		row_kind_e         kind;
		logic [IDX_W-1:0]  index;
		logic [DATA_W-1:0] data;
		sticks_t           sticks;
		logic              typed;
		command_t          want;
	} dir_row_t;

	// where a random stick value lands relative to the thresholds
	typedef enum int {ZONE_LOW, ZONE_HIGH, ZONE_EDGE, ZONE_ANY} zone_e;

	// receiver behavior, picked at random by the receiver process
	typedef enum int {RX_OPEN, RX_CHOPPY, RX_SLOW} rx_mode_e;

	localparam command_t UNTYPED   = '0;
	localparam sticks_t  NO_STICKS = '0;

	// directed table: typed expectations only where obvious, the rest predicted
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// centered sticks and throttle
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd1500, 12'd1500}, 1'b1,
			'{15'sd1500, 15'sd1500, 15'sd1500, 12'd1500, '{ARM_OFF, 1'b0, 1'b0, 1'b0}}},
		// all fields at full scale
		'{ROW_FRAME, '0, '0, '{12'd4095, 12'd4095, 12'd4095, 12'd4095}, 1'b1,
			'{15'sd4095, 15'sd4095, 15'sd4095, 12'd4095, '{ARM_OFF, 1'b0, 1'b0, 1'b0}}},
		// sticks at zero, throttle high
		'{ROW_FRAME, '0, '0, '{12'd0, 12'd0, 12'd0, 12'd4095}, 1'b1,
			'{15'sd0, 15'sd0, 15'sd0, 12'd4095, '{ARM_OFF, 1'b0, 1'b0, 1'b0}}},
		// throttle low, yaw centered: integrator clear only
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd1500, 12'd0}, 1'b1,
			'{15'sd1500, 15'sd1500, 15'sd1500, 12'd0, '{ARM_OFF, 1'b1, 1'b0, 1'b0}}},
		// yaw high three times: pending, armed with feedback clear, held
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd4095, 12'd0}, 1'b1,
			'{15'sd1500, 15'sd1500, 15'sd4095, 12'd0, '{ARM_PEND, 1'b1, 1'b0, 1'b0}}},
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd4095, 12'd0}, 1'b1,
			'{15'sd1500, 15'sd1500, 15'sd4095, 12'd0, '{ARM_ON, 1'b1, 1'b1, 1'b0}}},
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd4095, 12'd0}, 1'b1,
			'{15'sd1500, 15'sd1500, 15'sd4095, 12'd0, '{ARM_ON, 1'b1, 1'b0, 1'b0}}},
		// yaw low with throttle up: state held
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd0, 12'd2000}, 1'b1,
			'{15'sd1500, 15'sd1500, 15'sd0, 12'd2000, '{ARM_ON, 1'b0, 1'b0, 1'b0}}},
		// yaw low with throttle down: disarm
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd0, 12'd0}, 1'b1,
			'{15'sd1500, 15'sd1500, 15'sd0, 12'd0, '{ARM_OFF, 1'b1, 1'b0, 1'b0}}},
		// re-zero gesture
		'{ROW_FRAME, '0, '0, '{12'd4095, 12'd0, 12'd0, 12'd0}, 1'b1,
			'{15'sd4095, 15'sd0, 15'sd0, 12'd0, '{ARM_OFF, 1'b1, 1'b0, 1'b1}}},
		// threshold edges
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd4095, 12'd1100}, 1'b0, UNTYPED},
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd1900, 12'd1099}, 1'b0, UNTYPED},
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd1901, 12'd1099}, 1'b0, UNTYPED},
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd1100, 12'd0}, 1'b0, UNTYPED},
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd1099, 12'd0}, 1'b0, UNTYPED},
		'{ROW_FRAME, '0, '0, '{12'd1901, 12'd1099, 12'd1099, 12'd0}, 1'b0, UNTYPED},
		// re-zero near misses
		'{ROW_FRAME, '0, '0, '{12'd1900, 12'd0, 12'd0, 12'd0}, 1'b0, UNTYPED},
		'{ROW_FRAME, '0, '0, '{12'd4095, 12'd1100, 12'd0, 12'd0}, 1'b0, UNTYPED},
		// alternating bit patterns
		'{ROW_FRAME, '0, '0, '{12'hAAA, 12'h555, 12'hAAA, 12'h555}, 1'b0, UNTYPED},
		'{ROW_FRAME, '0, '0, '{12'h555, 12'hAAA, 12'h555, 12'hAAA}, 1'b0, UNTYPED},
		// crossed thresholds: a yaw both high and low ends disarmed
		'{ROW_WRITE, REG_LOW_THR, 12'd2000, NO_STICKS, 1'b0, UNTYPED},
		'{ROW_WRITE, REG_HIGH_THR, 12'd1000, NO_STICKS, 1'b0, UNTYPED},
		'{ROW_FRAME, '0, '0, '{12'd1500, 12'd1500, 12'd1500, 12'd0}, 1'b0, UNTYPED},
		// zero scale after masking of the upper data bits: divide by one
		'{ROW_WRITE, REG_RP_SCALE, 12'h100, NO_STICKS, 1'b0, UNTYPED},
		'{ROW_WRITE, REG_YAW_SCALE, 12'hF00, NO_STICKS, 1'b0, UNTYPED},
		'{ROW_FRAME, '0, '0, '{12'd0, 12'd4095, 12'd4095, 12'd4095}, 1'b0, UNTYPED},
		// largest divisor
		'{ROW_WRITE, REG_RP_SCALE, 12'd255, NO_STICKS, 1'b0, UNTYPED},
		'{ROW_WRITE, REG_YAW_SCALE, 12'd255, NO_STICKS, 1'b0, UNTYPED},
		'{ROW_FRAME, '0, '0, '{12'd0, 12'd4095, 12'd1, 12'd4095}, 1'b0, UNTYPED},
		'{ROW_FRAME, '0, '0, '{12'd1501, 12'd1499, 12'd2000, 12'd4095}, 1'b0, UNTYPED}
	};

	logic clk = 1'b0;
	logic arst_n;

	ssa_frame_if frame_ch ();
	ssa_cmd_if   cmd_ch ();
	ssa_cfg_if   cfg_ch ();

	stick_scaling_and_arming u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.frame  (frame_ch),
		.cmd    (cmd_ch),
		.cfg    (cfg_ch)
	);

	// mirror of the block's registers and arming state
	logic [STICK_W-1:0] cfg_low;
	logic [STICK_W-1:0] cfg_high;
	logic [SCALE_W-1:0] cfg_rp_scale;
	logic [SCALE_W-1:0] cfg_yaw_scale;
	logic [ARM_W-1:0]   arm_now;

	// commands predicted for accepted frames, oldest first
	command_t pending_cmds [$];

	int errors       = 0;
	int idle_cycles  = 0;
	int rx_stall_left = 0;
	int rx_mode_left  = 0;
	rx_mode_e rx_mode = RX_OPEN;

	always #(HALF_PERIOD) clk = ~clk;

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// (x - center) * 4 / scale + center, truncating toward zero, zero scale as one
	function automatic logic signed [CMD_W-1:0] rescaled(input logic [STICK_W-1:0] x,
		input logic [SCALE_W-1:0] scale);
		int divisor;
		int v;
		divisor = (scale == '0) ? 1 : int'(scale);
		v = (int'(x) - int'(CENTER_US)) * UNITY_GAIN / divisor + int'(CENTER_US);
		return v[CMD_W-1:0];
	endfunction

	// command for one frame; advances the mirrored arming state
	function automatic command_t predict_cmd(input sticks_t s);
		command_t c;
		logic yaw_high;
		logic yaw_low;
		c.roll     = rescaled(s.roll, cfg_rp_scale);
		c.pitch    = rescaled(s.pitch, cfg_rp_scale);
		c.yaw      = rescaled(s.yaw, cfg_yaw_scale);
		c.throttle = s.throttle;
		c.flags    = '0;
		// gestures count only with the throttle down
		if (s.throttle < cfg_low) begin
			yaw_high = s.yaw > cfg_high;
			yaw_low  = s.yaw < cfg_low;
			c.flags.clear_integrals = 1'b1;
			// pending to armed first, so one frame never steps twice
			if (yaw_high && arm_now == ARM_PEND) begin
				arm_now = ARM_ON;
				c.flags.clear_feedback = 1'b1;
			end
			if (yaw_high && arm_now == ARM_OFF)
				arm_now = ARM_PEND;
			// low yaw wins, also with crossed thresholds
			if (yaw_low)
				arm_now = ARM_OFF;
			if (yaw_low && s.roll > cfg_high && s.pitch < cfg_low)
				c.flags.rezero_request = 1'b1;
		end
		c.flags.status = arm_now;
		return c;
	endfunction

	function automatic string fmt_cmd(input command_t c);
		return $sformatf("roll %0d pitch %0d yaw %0d thr %0d arm %0d ci %b cf %b rz %b",
			c.roll, c.pitch, c.yaw, c.throttle, c.flags.status,
			c.flags.clear_integrals, c.flags.clear_feedback, c.flags.rezero_request);
	endfunction

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	// one stick value in the requested zone; falls back to any value where the
	// zone is empty under the current thresholds
	function automatic logic [STICK_W-1:0] pick_stick(input zone_e zone);
		case (zone)
			ZONE_LOW: begin
				if (cfg_low != '0)
					return STICK_W'($urandom_range(int'(cfg_low) - 1, 0));
			end
			ZONE_HIGH: begin
				if (cfg_high != '1)
					return STICK_W'($urandom_range(4095, int'(cfg_high) + 1));
			end
			ZONE_EDGE: begin
				case ($urandom_range(0, 3))
					0: return cfg_low;
					1: return cfg_low - 1'b1;
					2: return cfg_high;
					default: return cfg_high + 1'b1;
				endcase
			end
			default: ;
		endcase
		return STICK_W'($urandom);
	endfunction

	// mostly arming and re-zero gestures with random content, some plain noise
	function automatic sticks_t random_sticks();
		sticks_t s;
		int pick;
		if ($urandom_range(0, 99) < 20) begin
			s = {pick_stick(ZONE_ANY), pick_stick(ZONE_ANY),
				pick_stick(ZONE_ANY), pick_stick(ZONE_ANY)};
			return s;
		end
		pick = $urandom_range(0, 9);
		s.throttle = pick_stick(pick < 7 ? ZONE_LOW : (pick < 9 ? ZONE_EDGE : ZONE_ANY));
		pick = $urandom_range(0, 9);
		s.yaw = pick_stick(pick < 4 ? ZONE_HIGH : (pick < 7 ? ZONE_LOW :
			(pick < 8 ? ZONE_EDGE : ZONE_ANY)));
		// re-zero attempt or free roll and pitch
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			s.roll  = pick_stick(ZONE_HIGH);
			s.pitch = pick_stick(ZONE_LOW);
		end else begin
			s.roll  = pick_stick(pick < 5 ? ZONE_EDGE : ZONE_ANY);
			s.pitch = pick_stick(pick < 5 ? ZONE_EDGE : ZONE_ANY);
		end
		return s;
	endfunction

	// present one frame, wait for the handshake, queue its command
	task automatic send_frame(input sticks_t s, input logic typed, input command_t want);
		command_t predicted;
		@(negedge clk);
		frame_ch.valid       <= 1'b1;
		frame_ch.roll_in     <= s.roll;
		frame_ch.pitch_in    <= s.pitch;
		frame_ch.yaw_in      <= s.yaw;
		frame_ch.throttle_in <= s.throttle;
		@(posedge clk);
		while (!frame_ch.ready)
			@(posedge clk);
		// predictor runs even for typed rows to keep the arming state in step
		predicted = predict_cmd(s);
		pending_cmds.push_back(typed ? want : predicted);
	endtask

	// sender gap: frame valid dropped for the requested length
	task automatic hold_off(input int n);
		repeat (n) begin
			@(negedge clk);
			frame_ch.valid <= 1'b0;
		end
	endtask

	// stop sending and let every queued command come out before a register write
	task automatic drain_pipeline();
		@(negedge clk);
		frame_ch.valid <= 1'b0;
		while (pending_cmds.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] index, input logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= index;
		cfg_ch.data  <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		case (index)
			REG_LOW_THR:   cfg_low       = data[STICK_W-1:0];
			REG_HIGH_THR:  cfg_high      = data[STICK_W-1:0];
			REG_RP_SCALE:  cfg_rp_scale  = data[SCALE_W-1:0];
			REG_YAW_SCALE: cfg_yaw_scale = data[SCALE_W-1:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic write_all(input logic [DATA_W-1:0] low, input logic [DATA_W-1:0] high,
		input logic [DATA_W-1:0] rp_scale, input logic [DATA_W-1:0] yaw_scale);
		write_reg(REG_LOW_THR, low);
		write_reg(REG_HIGH_THR, high);
		write_reg(REG_RP_SCALE, rp_scale);
		write_reg(REG_YAW_SCALE, yaw_scale);
	endtask

	initial begin
		int burst_left;
		burst_left = 0;

		// everything known from time zero, reset held
		arst_n               = 1'b0;
		frame_ch.valid       = 1'b0;
		frame_ch.roll_in     = '0;
		frame_ch.pitch_in    = '0;
		frame_ch.yaw_in      = '0;
		frame_ch.throttle_in = '0;
		cfg_ch.valid         = 1'b0;
		cfg_ch.index         = '0;
		cfg_ch.data          = '0;
		cmd_ch.ready         = 1'b0;
		cfg_low              = LOW_THR_RST;
		cfg_high             = HI_THR_RST;
		cfg_rp_scale         = SCALE_RST;
		cfg_yaw_scale        = SCALE_RST;
		arm_now              = ARM_OFF;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table
		foreach (DIR_ROWS[i]) begin
			if (DIR_ROWS[i].kind == ROW_WRITE) begin
				drain_pipeline();
				write_reg(DIR_ROWS[i].index, DIR_ROWS[i].data);
			end else begin
				send_frame(DIR_ROWS[i].sticks, DIR_ROWS[i].typed, DIR_ROWS[i].want);
				hold_off($urandom_range(0, 2));
			end
		end

		// random phases, one register setting each
		for (int ph = 0; ph < PHASES; ph++) begin
			drain_pipeline();
			case (ph)
				0: write_all(12'd1100, 12'd1900, 12'd4, 12'd4);
				// nothing below or above: arming can never trigger, widest outputs
				1: write_all(12'd0, 12'd4095, 12'd1, 12'd1);
				// nearly everything low and high, smallest gain
				2: write_all(12'd4095, 12'd0, 12'd255, 12'd255);
				// crossed thresholds and zero scales hidden in the upper data bits
				3: write_all(12'd2000, 12'd1000, 12'hF00, 12'h100);
				default: write_all(DATA_W'($urandom_range(700, 1500)),
					DATA_W'($urandom_range(1500, 2300)),
					DATA_W'($urandom), DATA_W'($urandom));
			endcase
			for (int n = 0; n < FRAMES_PER_PHASE; n++) begin
				// bursts of random length, gaps between most of them
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					if ($urandom_range(0, 2) != 0)
						hold_off($urandom_range(1, 8));
				end
				burst_left--;
				send_frame(random_sticks(), 1'b0, UNTYPED);
			end
		end

		drain_pipeline();
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// command receiver: stall pattern with its own modes
	// ------------------------------------------------------------------------
	always @(negedge clk) begin
		if (rx_mode_left == 0) begin
			rx_mode      = rx_mode_e'($urandom_range(0, 2));
			rx_mode_left = $urandom_range(50, 300);
		end else begin
			rx_mode_left--;
		end
		if (rx_stall_left != 0) begin
			cmd_ch.ready <= 1'b0;
			rx_stall_left--;
		end else begin
			cmd_ch.ready <= 1'b1;
			case (rx_mode)
				RX_OPEN:   rx_stall_left = 0;
				RX_CHOPPY: rx_stall_left = $urandom_range(0, 2);
				default:   rx_stall_left = $urandom_range(4, 12);
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// command checker
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		command_t got;
		command_t want;
		if (arst_n && cmd_ch.valid && cmd_ch.ready) begin
			got.roll     = cmd_ch.roll_out;
			got.pitch    = cmd_ch.pitch_out;
			got.yaw      = cmd_ch.yaw_out;
			got.throttle = cmd_ch.throttle_out;
			got.flags    = '{cmd_ch.arm_status, cmd_ch.clear_integrals,
				cmd_ch.clear_feedback, cmd_ch.rezero_request};
			if (pending_cmds.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("unexpected command: %s", fmt_cmd(got));
			end else begin
				want = pending_cmds.pop_front();
				if (got.roll !== want.roll || got.pitch !== want.pitch ||
					got.yaw !== want.yaw || got.throttle !== want.throttle ||
					got.flags.status !== want.flags.status ||
					got.flags.clear_integrals !== want.flags.clear_integrals ||
					got.flags.clear_feedback !== want.flags.clear_feedback ||
					got.flags.rezero_request !== want.flags.rezero_request) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("command mismatch at %0t\n  want %s\n  got  %s",
							$realtime, fmt_cmd(want), fmt_cmd(got));
				end
			end
		end
	end

	// watchdog: any handshake on any channel counts as progress
	always @(posedge clk) begin
		if (!arst_n || (frame_ch.valid && frame_ch.ready) ||
			(cmd_ch.valid && cmd_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule
